>>> rtl/cppl_pkg.sv
// Shared constants, types, controller interface and helper functions for the path lookup core.
package cppl_pkg;

  // Store size and coordinate width.
  localparam int MAX_CORNERS   = 128;
  localparam int COORD_BITS    = 16;
  localparam int IDX_BITS      = $clog2(MAX_CORNERS);
  localparam int CNT_BITS      = $clog2(MAX_CORNERS + 1);
  // A segment is at most 2 * (2^COORD_BITS - 1) long, and there are at most MAX_CORNERS of them.
  localparam int RL_BITS       = COORD_BITS + 2 + IDX_BITS;

  // Fixed widths of the stream fields.
  localparam int FIELD_BITS    = 16;
  localparam int TIME_BITS     = 31;
  localparam int DIV_CNT_BITS  = $clog2(TIME_BITS);
  localparam int IN_DATA_BITS  = 64;
  localparam int OUT_DATA_BITS = 32;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic        [COORD_BITS:0]   adiff_t;
  typedef logic        [RL_BITS-1:0]    rl_t;
  typedef logic        [CNT_BITS-1:0]   cnt_t;
  typedef logic        [IDX_BITS-1:0]   idx_t;
  typedef logic signed [FIELD_BITS-1:0] field_t;
  typedef logic        [TIME_BITS-1:0]  time_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LD_STORE,
    ST_LD_CLOSE,
    ST_Q_CHECK,
    ST_DIV,
    ST_SRCH_PRIME,
    ST_SRCH,
    ST_RD_SEG,
    ST_RD_NXT,
    ST_GOT_NXT,
    ST_CALC_STEP,
    ST_CALC_POS,
    ST_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic ld_store;
    logic ld_close;
    logic set_nopath;
    logic div_start;
    logic div_step;
    logic scan_clear;
    logic scan_inc;
    logic scan_adv;
    logic seg_cap;
    logic corner_sel_nxt;
    logic cap0;
    logic cap1;
    logic calc_step;
    logic calc_pos;
    logic out_load;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic in_query;
    logic in_last;
    logic path_ok;
    logic div_last;
    logic scan_hit;
    logic scan_end;
    logic out_free;
  } sts_t;

  // Wraps a 16-bit field into the stored coordinate width.
  function automatic coord_t wrap_coord(field_t v);
    logic [31:0] w;
    w = 32'(v);
    return w[COORD_BITS-1:0];
  endfunction

  // Sign-extends a stored coordinate and keeps the low 16 bits for the result.
  function automatic field_t to_field(coord_t c);
    logic [31:0] w;
    w = 32'(c);
    return w[FIELD_BITS-1:0];
  endfunction

  // Absolute difference of two coordinates.
  function automatic adiff_t absdiff(coord_t a, coord_t b);
    logic signed [COORD_BITS:0] d;
    d = (COORD_BITS + 1)'(a) - (COORD_BITS + 1)'(b);
    return d[COORD_BITS] ? adiff_t'(-d) : adiff_t'(d);
  endfunction

  // Rectilinear length of the segment between two corners.
  function automatic rl_t seg_len(coord_t ax, coord_t ay, coord_t bx, coord_t by);
    return RL_BITS'(absdiff(ax, bx)) + RL_BITS'(absdiff(ay, by));
  endfunction

  // Moves from one coordinate toward another by the given distance.
  function automatic coord_t walk(coord_t from, coord_t to, adiff_t amount);
    logic signed [COORD_BITS+1:0] f;
    logic signed [COORD_BITS+1:0] s;
    logic signed [COORD_BITS+1:0] r;
    f = (COORD_BITS + 2)'(from);
    s = $signed({1'b0, amount});
    r = (to >= from) ? f + s : f - s;
    return r[COORD_BITS-1:0];
  endfunction

endpackage

>>> rtl/cppl_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module cppl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/cppl_ctrl.sv
// Controller state machine that sequences corner loads and position queries.
module cppl_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  cppl_pkg::sts_t sts,
  output cppl_pkg::cmd_t cmd
);

  import cppl_pkg::*;

  state_t state;
  state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign s_tready = (state == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.accept = 1'b1;
          state_next = sts.in_query ? ST_Q_CHECK : ST_LD_STORE;
        end
      end
      ST_LD_STORE: begin
        cmd.ld_store = 1'b1;
        state_next   = sts.in_last ? ST_LD_CLOSE : ST_IDLE;
      end
      ST_LD_CLOSE: begin
        cmd.ld_close = 1'b1;
        state_next   = ST_IDLE;
      end
      ST_Q_CHECK: begin
        cmd.scan_clear = 1'b1;
        if (sts.path_ok) begin
          cmd.div_start = 1'b1;
          state_next    = ST_DIV;
        end else begin
          cmd.set_nopath = 1'b1;
          state_next     = ST_OUT;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_next = ST_SRCH_PRIME;
        end
      end
      ST_SRCH_PRIME: begin
        cmd.scan_inc = 1'b1;
        state_next   = ST_SRCH;
      end
      ST_SRCH: begin
        if (sts.scan_hit || sts.scan_end) begin
          cmd.seg_cap = 1'b1;
          state_next  = ST_RD_SEG;
        end else begin
          cmd.scan_adv = 1'b1;
        end
      end
      ST_RD_SEG: begin
        state_next = ST_RD_NXT;
      end
      ST_RD_NXT: begin
        cmd.corner_sel_nxt = 1'b1;
        cmd.cap0           = 1'b1;
        state_next         = ST_GOT_NXT;
      end
      ST_GOT_NXT: begin
        cmd.cap1   = 1'b1;
        state_next = ST_CALC_STEP;
      end
      ST_CALC_STEP: begin
        cmd.calc_step = 1'b1;
        state_next    = ST_CALC_POS;
      end
      ST_CALC_POS: begin
        cmd.calc_pos = 1'b1;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

>>> rtl/cppl_dp.sv
// Datapath: corner and running-length stores, remainder unit, scan and position arithmetic.
module cppl_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  cppl_pkg::cmd_t                      cmd,
  output cppl_pkg::sts_t                      sts,
  input  logic [cppl_pkg::IN_DATA_BITS-1:0]   s_tdata,
  input  logic                                s_tlast,
  input  logic                                s_tuser,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  output logic [cppl_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic                                m_tuser
);

  import cppl_pkg::*;

  // Path state.
  cnt_t   count;
  rl_t    perimeter;
  logic   closed;
  coord_t prev_x;
  coord_t prev_y;
  coord_t first_x;
  coord_t first_y;

  // Latched input transaction.
  coord_t in_x;
  coord_t in_y;
  logic   in_last;
  time_t  in_time;

  // Remainder unit.
  rl_t                     div_rem;
  time_t                   div_q;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [RL_BITS:0]        div_shift;
  logic [RL_BITS:0]        div_diff;

  // Scan and segment.
  cnt_t scan_idx;
  rl_t  base;
  rl_t  rem;
  idx_t seg;
  idx_t nxt;

  // Corner operands and walk.
  coord_t x0;
  coord_t y0;
  coord_t x1;
  coord_t y1;
  adiff_t adx;
  adiff_t step_x;
  adiff_t step_y;
  rl_t    adx_ext;
  rl_t    stepx_ext;
  rl_t    rem_y;

  // Result and output register.
  field_t res_x;
  field_t res_y;
  logic   res_status;
  field_t out_x;
  field_t out_y;
  logic   out_status;
  logic   out_valid;

  // Load arithmetic.
  cnt_t cnt_eff;
  rl_t  per_eff;
  logic store_ok;
  rl_t  per_add;
  rl_t  per_close;

  // Memory ports.
  logic   c_we;
  idx_t   c_waddr;
  idx_t   c_raddr;
  coord_t cx_rdata;
  coord_t cy_rdata;
  logic   rl_we;
  idx_t   rl_waddr;
  rl_t    rl_wdata;
  rl_t    rl_rdata;

  // Load step: a load after the path was closed starts a new path.
  always_comb begin
    cnt_eff   = closed ? '0 : count;
    per_eff   = closed ? '0 : perimeter;
    store_ok  = (cnt_eff < CNT_BITS'(MAX_CORNERS));
    per_add   = per_eff + seg_len(prev_x, prev_y, in_x, in_y);
    per_close = perimeter + seg_len(prev_x, prev_y, first_x, first_y);
  end

  // Memory write and read addressing.
  always_comb begin
    c_we     = cmd.ld_store && store_ok;
    c_waddr  = cnt_eff[IDX_BITS-1:0];
    c_raddr  = cmd.corner_sel_nxt ? nxt : seg;
    rl_we    = (cmd.ld_store && store_ok && (cnt_eff != '0)) || cmd.ld_close;
    if (cmd.ld_close) begin
      rl_waddr = IDX_BITS'(count - CNT_BITS'(1));
      rl_wdata = per_close;
    end else begin
      rl_waddr = IDX_BITS'(cnt_eff - CNT_BITS'(1));
      rl_wdata = per_add;
    end
  end

  cppl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_CORNERS)) u_x_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (in_x),
    .raddr (c_raddr),
    .rdata (cx_rdata)
  );

  cppl_ram #(.WIDTH(COORD_BITS), .DEPTH(MAX_CORNERS)) u_y_ram (
    .clk   (clk),
    .we    (c_we),
    .waddr (c_waddr),
    .wdata (in_y),
    .raddr (c_raddr),
    .rdata (cy_rdata)
  );

  cppl_ram #(.WIDTH(RL_BITS), .DEPTH(MAX_CORNERS)) u_rl_ram (
    .clk   (clk),
    .we    (rl_we),
    .waddr (rl_waddr),
    .wdata (rl_wdata),
    .raddr (scan_idx[IDX_BITS-1:0]),
    .rdata (rl_rdata)
  );

  // Path control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      perimeter <= '0;
      closed    <= 1'b0;
    end else if (cmd.ld_store) begin
      closed    <= 1'b0;
      count     <= store_ok ? cnt_eff + CNT_BITS'(1) : cnt_eff;
      perimeter <= (store_ok && (cnt_eff != '0)) ? per_add : per_eff;
    end else if (cmd.ld_close) begin
      closed    <= 1'b1;
      perimeter <= per_close;
    end
  end

  // Corner registers and input latch.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      in_x    <= wrap_coord(field_t'(s_tdata[FIELD_BITS-1:0]));
      in_y    <= wrap_coord(field_t'(s_tdata[2*FIELD_BITS-1:FIELD_BITS]));
      in_last <= s_tlast;
      in_time <= s_tdata[2*FIELD_BITS+TIME_BITS-1:2*FIELD_BITS];
    end
    if (cmd.ld_store && store_ok) begin
      prev_x <= in_x;
      prev_y <= in_y;
      if (cnt_eff == '0) begin
        first_x <= in_x;
        first_y <= in_y;
      end
    end
  end

  // Restoring remainder, one dividend bit per cycle.
  always_comb begin
    div_shift = {div_rem, div_q[TIME_BITS-1]};
    div_diff  = div_shift - {1'b0, perimeter};
  end

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      div_rem <= '0;
      div_q   <= in_time;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_rem <= (div_shift >= {1'b0, perimeter}) ? div_diff[RL_BITS-1:0]
                                                  : div_shift[RL_BITS-1:0];
      div_q   <= {div_q[TIME_BITS-2:0], 1'b0};
      div_cnt <= div_cnt + DIV_CNT_BITS'(1);
    end
  end

  // Scan of running lengths, one entry per cycle.
  always_ff @(posedge clk) begin
    if (cmd.scan_clear) begin
      scan_idx <= '0;
      base     <= '0;
    end else if (cmd.scan_inc) begin
      scan_idx <= scan_idx + CNT_BITS'(1);
    end else if (cmd.scan_adv) begin
      scan_idx <= scan_idx + CNT_BITS'(1);
      base     <= rl_rdata;
    end
    if (cmd.seg_cap) begin
      seg <= IDX_BITS'(scan_idx - CNT_BITS'(1));
      nxt <= (scan_idx >= count) ? '0 : scan_idx[IDX_BITS-1:0];
      rem <= div_rem - base;
    end
  end

  // Corner capture and the two walk steps.
  always_comb begin
    adx       = absdiff(x0, x1);
    adx_ext   = RL_BITS'(adx);
    stepx_ext = (rem < adx_ext) ? rem : adx_ext;
    rem_y     = rem - stepx_ext;
  end

  always_ff @(posedge clk) begin
    if (cmd.cap0) begin
      x0 <= cx_rdata;
      y0 <= cy_rdata;
    end
    if (cmd.cap1) begin
      x1 <= cx_rdata;
      y1 <= cy_rdata;
    end
    if (cmd.calc_step) begin
      step_x <= stepx_ext[COORD_BITS:0];
      step_y <= rem_y[COORD_BITS:0];
    end
    if (cmd.set_nopath) begin
      res_x      <= '0;
      res_y      <= '0;
      res_status <= 1'b1;
    end else if (cmd.calc_pos) begin
      res_x      <= to_field(walk(x0, x1, step_x));
      res_y      <= to_field(walk(y0, y1, step_y));
      res_status <= 1'b0;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
    if (cmd.out_load) begin
      out_x      <= res_x;
      out_y      <= res_y;
      out_status <= res_status;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_y, out_x};
  assign m_tuser  = out_status;

  // Status to the controller.
  always_comb begin
    sts.in_query = s_tuser;
    sts.in_last  = in_last;
    sts.path_ok  = closed && (perimeter != '0);
    sts.div_last = (div_cnt == DIV_CNT_BITS'(TIME_BITS - 1));
    sts.scan_hit = (rl_rdata > div_rem);
    sts.scan_end = (scan_idx >= count);
    sts.out_free = !out_valid || m_tready;
  end

  // The partial remainder always stays below the perimeter.
  a_div_range: assert property (@(posedge clk) disable iff (rst)
    cmd.div_step |-> (div_rem < perimeter))
    else $error("remainder not below perimeter");

  // Every entry passed over in the scan lies at or below the reduced time.
  a_base_le_time: assert property (@(posedge clk) disable iff (rst)
    cmd.seg_cap |-> (base <= div_rem))
    else $error("segment base above reduced time");

  // A closed path holds at least one corner.
  a_closed_count: assert property (@(posedge clk) disable iff (rst)
    closed |-> (count != '0))
    else $error("closed path without corners");

  // A new result is loaded only when the output register is free.
  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("result overwritten before it was taken");

endmodule

>>> rtl/closed_path_position_lookup_core.sv
// Top level of the closed path position lookup core: controller and datapath.
// Load transaction: ST_LD_STORE, plus ST_LD_CLOSE for the corner that closes the path; no result.
// Query transaction: a bit-serial remainder unit reduces the query time by the perimeter, then
// a scan of the running-length RAM at one entry per cycle finds the segment s (0 to
// MAX_CORNERS-1), and the position on it is computed. A query on an open path or a zero
// perimeter returns a zero position with status set. One transaction is in work at a time.
// Reset clears the corner count, perimeter and closed flag; RAM contents are not cleared.
module closed_path_position_lookup_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // corner_x [15:0], corner_y [31:16], query_time [62:32], zero [63]
  input  logic [cppl_pkg::IN_DATA_BITS-1:0]   s_tdata,
  input  logic                                s_tlast,   // last_corner
  input  logic                                s_tuser,   // req_type
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // pos_x [15:0], pos_y [31:16]
  output logic [cppl_pkg::OUT_DATA_BITS-1:0]  m_tdata,
  output logic                                m_tuser    // status
);

  import cppl_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer.
  cppl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Storage and arithmetic.
  cppl_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .sts      (sts),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

endmodule
